// ===== sv/mafs_pkg.sv =====
// ----------------------------------------------------------------------------
// mafs_pkg: shared types and constants for the mpeg audio frame sync scanner
// Holds the decoded header fields, the result record, the packed bus widths
// and the layer ii bitrate/mode table.
// ----------------------------------------------------------------------------
package mafs_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;

  // raw version id and layer id codes from the header
  localparam logic [1:0] VID_MPEG1  = 2'd3;
  localparam logic [1:0] VID_MPEG2  = 2'd2;
  localparam logic [1:0] VID_RESVD  = 2'd1;
  localparam logic [1:0] LID_RESVD  = 2'd0;
  localparam logic [1:0] LID_LAYER2 = 2'd2;

  // reported version codes
  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  localparam logic [3:0] BRI_BAD   = 4'hF;
  localparam logic [1:0] SRI_BAD   = 2'd3;
  localparam logic [1:0] EMPH_BAD  = 2'd2;
  localparam logic [1:0] MODE_MONO = 2'd3;

  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [2:0]  SYNC_HIGH  = 3'b111;
  localparam logic [23:0] ID3_MAGIC  = 24'h494433;    // "ID3"
  localparam logic [31:0] AID_MAGIC  = 32'h41694401;  // "AiD" then 0x01

  // layer ii channel-mode group per bitrate index
  localparam logic [1:0] L2_MONO   = 2'd0;
  localparam logic [1:0] L2_STEREO = 2'd1;
  localparam logic [1:0] L2_ANY    = 2'd2;

  // listed from index 15 down to index 0
  localparam logic [15:0][1:0] L2_ALLOW = {
    L2_STEREO, L2_STEREO, L2_STEREO, L2_STEREO, L2_STEREO, L2_ANY, L2_ANY, L2_ANY,
    L2_ANY, L2_ANY, L2_MONO, L2_ANY, L2_MONO, L2_MONO, L2_MONO, L2_ANY
  };

  typedef struct packed {
    logic [1:0]  channel_mode;
    logic [1:0]  sample_rate_index;
    logic        free_format;
    logic [3:0]  bitrate_index;
    logic [1:0]  layer_number;
    logic [1:0]  mpeg_version;
    logic [31:0] header_word;
  } hdr_fields_t;

  typedef struct packed {
    logic        found;
    hdr_fields_t hdr;
    logic [31:0] header_offset;
  } result_t;

  function automatic logic layer2_mode_ok(input logic [3:0] bri, input logic [1:0] mode);
    logic [1:0] allow;
    logic [1:0] grp;
    allow = L2_ALLOW[bri];
    grp   = (mode == MODE_MONO) ? L2_MONO : L2_STEREO;
    return (allow == L2_ANY) || (allow == grp);
  endfunction

endpackage

// ===== sv/mafs_hdr_check.sv =====
// ----------------------------------------------------------------------------
// mafs_hdr_check: sanity check of one 4-byte mpeg audio header window
// Flags a sane header and decodes its fields; purely combinational.
// ----------------------------------------------------------------------------
module mafs_hdr_check (
  input  logic [31:0]          word,
  output logic                 sane,
  output mafs_pkg::hdr_fields_t fields
);

  logic [1:0] vid;
  logic [1:0] lid;
  logic [3:0] bri;
  logic [1:0] sri;
  logic [1:0] mode;
  logic       sync_ok;
  logic       codes_ok;
  logic       l2_ok;

  assign vid  = word[20:19];
  assign lid  = word[18:17];
  assign bri  = word[15:12];
  assign sri  = word[11:10];
  assign mode = word[7:6];

  assign sync_ok  = (word[31:24] == mafs_pkg::SYNC_BYTE) && (word[23:21] == mafs_pkg::SYNC_HIGH);
  assign codes_ok = (vid != mafs_pkg::VID_RESVD) && (lid != mafs_pkg::LID_RESVD) &&
                    (bri != mafs_pkg::BRI_BAD) && (sri != mafs_pkg::SRI_BAD) &&
                    (word[1:0] != mafs_pkg::EMPH_BAD);
  // only mpeg-1 layer ii restricts the mode per bitrate
  assign l2_ok    = !((vid == mafs_pkg::VID_MPEG1) && (lid == mafs_pkg::LID_LAYER2)) ||
                    mafs_pkg::layer2_mode_ok(bri, mode);
  assign sane     = sync_ok && codes_ok && l2_ok;

  always_comb begin
    fields = '0;
    fields.header_word       = word;
    fields.layer_number      = 2'(3'd4 - {1'b0, lid});
    fields.bitrate_index     = bri;
    fields.free_format       = (bri == 4'd0);
    fields.sample_rate_index = sri;
    fields.channel_mode      = mode;
    unique case (vid)
      mafs_pkg::VID_MPEG1: fields.mpeg_version = mafs_pkg::VER_MPEG1;
      mafs_pkg::VID_MPEG2: fields.mpeg_version = mafs_pkg::VER_MPEG2;
      default:             fields.mpeg_version = mafs_pkg::VER_MPEG25;
    endcase
  end

endmodule

// ===== sv/mafs_scan_core.sv =====
// ----------------------------------------------------------------------------
// mafs_scan_core: tag skipping and header search state for one byte per cycle while take is high
// Keeps the ten newest bytes, the file position and the skip count, and
// checks all windows of the byte block in parallel.
// ----------------------------------------------------------------------------
module mafs_scan_core #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                start_of_file,
  input  logic                end_of_file,
  output logic                res_valid,
  output mafs_pkg::result_t   res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_COLLECT = 3'd1;
  localparam logic [2:0] PH_TAGSKIP = 3'd2;
  localparam logic [2:0] PH_AIDSKIP = 3'd3;
  localparam logic [2:0] PH_SCAN    = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  logic [2:0]             phase, phase_next, ph_e;
  logic [7:0]             recent [10];
  logic [7:0]             recent_next [10];
  logic [7:0]             rec_e [10];
  logic [7:0]             rec_new [10];
  logic [OFFSET_BITS-1:0] pos, pos_next, pos_e;
  logic [OFFSET_BITS-1:0] blk_pos, scan_pos;
  logic [27:0]            skip, skip_next, skip_e, skip_dec;
  logic [3:0]             fill, fill_next, fill_e, fill_inc, blk_fill, first;

  logic [6:0]             sane;
  logic [6:0]             hit;
  mafs_pkg::hdr_fields_t  fields [7];
  mafs_pkg::result_t      blk_res;
  logic                   is_id3, is_aid, aid_long;
  logic [27:0]            tag_len;
  logic [15:0]            aid_len;

  // state as seen by this item, after an optional restart
  always_comb begin
    ph_e   = phase;
    pos_e  = pos;
    skip_e = skip;
    fill_e = fill;
    rec_e  = recent;
    if (start_of_file) begin
      ph_e   = PH_COLLECT;
      pos_e  = '0;
      skip_e = '0;
      fill_e = '0;
      for (int i = 0; i < 10; i++) rec_e[i] = '0;
    end
    for (int i = 0; i < 9; i++) rec_new[i] = rec_e[i+1];
    rec_new[9] = data_byte;
  end

  for (genvar s = 0; s < 7; s++) begin : g_win
    mafs_hdr_check u_chk (
      .word   ({rec_new[s], rec_new[s+1], rec_new[s+2], rec_new[s+3]}),
      .sane   (sane[s]),
      .fields (fields[s])
    );
  end

  assign is_id3   = ({rec_new[0], rec_new[1], rec_new[2]} == mafs_pkg::ID3_MAGIC);
  assign is_aid   = ({rec_new[0], rec_new[1], rec_new[2], rec_new[3]} == mafs_pkg::AID_MAGIC);
  // synchsafe length, seven bits per byte
  assign tag_len  = {rec_new[6][6:0], rec_new[7][6:0], rec_new[8][6:0], rec_new[9][6:0]};
  assign aid_len  = {rec_new[5], rec_new[4]};
  assign aid_long = |aid_len[15:2];
  // a short aid length starts the window search inside the block
  assign first    = (is_aid && !aid_long) ? (4'd6 + {2'b00, aid_len[1:0]}) : 4'd0;
  assign blk_fill = (first >= 4'd8) ? (4'd10 - first) : 4'd3;
  assign fill_inc = (fill_e < 4'd4) ? (fill_e + 4'd1) : fill_e;
  assign skip_dec = (skip_e != '0) ? (skip_e - 28'd1) : skip_e;
  assign scan_pos = pos_e - OFFSET_BITS'(3);

  always_comb begin
    for (int s = 0; s < 7; s++) hit[s] = sane[s] && (4'(s) >= first);
  end

  // lowest hitting window wins
  always_comb begin
    blk_res = '0;
    blk_pos = '0;
    for (int s = 6; s >= 0; s--) begin
      if (hit[s]) begin
        blk_res.found = 1'b1;
        blk_res.hdr   = fields[s];
        blk_pos       = pos_e - OFFSET_BITS'(9 - s);
      end
    end
    blk_res.header_offset = 32'(blk_pos);
  end

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    skip_next   = skip;
    fill_next   = fill;
    recent_next = recent;
    res_valid   = 1'b0;
    res         = '0;
    if (take) begin
      phase_next  = ph_e;
      pos_next    = pos_e;
      skip_next   = skip_e;
      fill_next   = fill_e;
      recent_next = rec_e;
      if (ph_e != PH_IDLE && ph_e != PH_DONE) begin
        pos_next    = pos_e + OFFSET_BITS'(1);
        recent_next = rec_new;
        unique case (ph_e)
          PH_COLLECT: begin
            fill_next = fill_e + 4'd1;
            if (fill_e >= 4'd9) begin
              if (is_id3) begin
                fill_next = '0;
                if (tag_len == '0) begin
                  phase_next = PH_COLLECT;
                end else begin
                  skip_next  = tag_len;
                  phase_next = PH_TAGSKIP;
                end
              end else if (is_aid && aid_long) begin
                fill_next  = '0;
                skip_next  = 28'(aid_len - 16'd4);
                phase_next = (aid_len == 16'd4) ? PH_SCAN : PH_AIDSKIP;
              end else if (|hit) begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res        = blk_res;
              end else begin
                fill_next  = blk_fill;
                phase_next = PH_SCAN;
              end
            end
          end
          PH_TAGSKIP, PH_AIDSKIP: begin
            skip_next = skip_dec;
            if (skip_dec == '0) begin
              fill_next  = '0;
              phase_next = (ph_e == PH_TAGSKIP) ? PH_COLLECT : PH_SCAN;
            end
          end
          PH_SCAN: begin
            fill_next = fill_inc;
            if (fill_inc >= 4'd4 && sane[6]) begin
              phase_next              = PH_DONE;
              res_valid               = 1'b1;
              res.found               = 1'b1;
              res.hdr                 = fields[6];
              res.header_offset       = 32'(scan_pos);
            end
          end
          default: ;
        endcase
        // end of file without a header gives an all-zero not-found item
        if (end_of_file && !res_valid) begin
          phase_next = PH_DONE;
          res_valid  = 1'b1;
          res        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos   <= '0;
      skip  <= '0;
      fill  <= '0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      skip  <= skip_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    recent <= recent_next;
  end

endmodule

// ===== sv/mpeg_audio_frame_sync_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// mpeg_audio_frame_sync_scanner_unit: finds the first sane mpeg audio header
//
// Input stream: one file byte per item in s_axis_tdata; s_axis_tuser marks
// the first byte of a file (restarts the scan at offset zero), s_axis_tlast
// the last one. Output stream: at most one item per file. m_axis_tuser is 1
// when a header was found, 0 when the file ended without one (then tdata is
// all zero). Leading id3v2 tags and one aid header are skipped first.
// Bytes outside a file, or after the result, are consumed and dropped.
// The byte that settles a result passes the input register, and the result
// then leaves through the result register (the output register).
// Throughput: one byte per cycle while the output does not stall; each byte
// goes through the window checks in a single pass, so the scan loop sets no
// limit beyond the clock. Reset clears the scan to waiting for a start byte
// and empties both registers. When the receiver holds m_axis_tready low with
// a result pending, the input register fills and s_axis_tready drops until
// the result is taken.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_sync_scanner_unit #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mafs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // data_byte
  input  logic                                 s_axis_tuser,   // start_of_file
  input  logic                                 s_axis_tlast,   // end_of_file
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // header_offset[31:0], header_word[63:32], mpeg_version[65:64],
  // layer_number[67:66], bitrate_index[71:68], free_format[72],
  // sample_rate_index[74:73], channel_mode[76:75], zero fill
  output logic [mafs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tuser    // found
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_sof;
  logic              in_eof;
  logic              advance;
  logic              take;
  logic              res_valid;
  mafs_pkg::result_t res;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign take          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_sof  <= s_axis_tuser;
      in_eof  <= s_axis_tlast;
    end
  end

  mafs_scan_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (in_byte),
    .start_of_file (in_sof),
    .end_of_file   (in_eof),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take && res_valid) begin
      m_axis_tuser <= res.found;
      m_axis_tdata <= {3'b000, res.hdr, res.header_offset};
    end
  end

endmodule

// ===== sv/mafs_sva.sv =====
// ----------------------------------------------------------------------------
// mafs_sva: port-level checks for the mpeg audio frame sync scanner
// Watches the result channel for reset behavior, stall stability and
// consistency of found and not-found items.
// ----------------------------------------------------------------------------
module mafs_sva (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mafs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("not-found item carries data");

  a_found_sync: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:53] == 11'h7FF)
    else $error("found item without frame sync");

  a_found_codes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[67:66] != 2'd0 && m_axis_tdata[65:64] != 2'd3)
    else $error("found item with bad version or layer");

endmodule

bind mpeg_audio_frame_sync_scanner_unit mafs_sva u_mafs_sva (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/mpeg_audio_frame_sync_scanner_unit_tb.sv =====
// ----------------------------------------------------------------------------
// mpeg_audio_frame_sync_scanner_unit_tb: self-checking bench for the scanner
// Streams generated audio files byte by byte: id3v2 tag chains, aid headers
// (short, normal and overlong), junk, broken and sane frame headers, truncated
// files and restarts. A local scan model predicts the result, if any, of each file and
// the monitor compares every output item field by field.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_sync_scanner_unit_tb;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int FILE_BYTES    = 850;
  localparam int RESULT_DATA_W = $bits(mafs_pkg::hdr_fields_t) + 32;

  typedef enum logic [2:0] {
    SCAN_WAIT, SCAN_PROLOGUE, SCAN_TAG_SKIP, SCAN_AID_SKIP, SCAN_SEARCH, SCAN_FINISHED
  } scan_phase_t;

  typedef enum int {
    FLT_SYNC, FLT_VERSION, FLT_LAYER, FLT_BITRATE, FLT_RATE, FLT_EMPHASIS, FLT_L2_MODE
  } header_fault_t;

  typedef struct {
    logic [7:0] data;
    logic       sof;
    logic       eof;
    bit         drain;   // wait for all results before offering this byte
  } file_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [mafs_pkg::IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                            s_axis_tuser  = 1'b0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [mafs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  file_byte_t         pending_bytes[$];
  mafs_pkg::result_t  expected_results[$];
  logic [7:0]         file_bytes[$];
  file_byte_t         next_byte;
  bit                 offer;
  bit                 byte_taken = 1'b0;
  int                 bytes_sent = 0;
  int                 cycles = 0;
  int                 mismatches = 0;
  int                 headers_found = 0;
  int                 files_missed = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  bit                 steady;
  mafs_pkg::result_t  fresh;
  mafs_pkg::result_t  want;

  // scan model state
  scan_phase_t phase = SCAN_WAIT;
  logic [7:0]  window[10];
  logic [31:0] file_pos = '0;
  logic [27:0] skip_left = '0;
  int          window_fill = 0;

  mpeg_audio_frame_sync_scanner_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign steady = (bytes_sent >= 400) && (bytes_sent < 560);

  function automatic bit frame_header_ok(input logic [31:0] w);
    logic [1:0] vid;
    logic [1:0] lid;
    logic [3:0] bri;
    vid = w[20:19];
    lid = w[18:17];
    bri = w[15:12];
    if (w[31:24] != mafs_pkg::SYNC_BYTE || w[23:21] != mafs_pkg::SYNC_HIGH) return 1'b0;
    if (vid == mafs_pkg::VID_RESVD || lid == mafs_pkg::LID_RESVD ||
        bri == mafs_pkg::BRI_BAD) return 1'b0;
    if (w[11:10] == mafs_pkg::SRI_BAD || w[1:0] == mafs_pkg::EMPH_BAD) return 1'b0;
    // mpeg-1 layer ii: mono up to index 10, stereo modes never at 1..3 or 5
    if (vid == mafs_pkg::VID_MPEG1 && lid == mafs_pkg::LID_LAYER2) begin
      if (w[7:6] == mafs_pkg::MODE_MONO) return bri < 4'd11;
      return !(bri >= 4'd1 && bri <= 4'd3) && bri != 4'd5;
    end
    return 1'b1;
  endfunction

  function automatic mafs_pkg::result_t header_result(input logic [31:0] w,
                                                      input logic [31:0] offs);
    mafs_pkg::result_t r;
    r.found                 = 1'b1;
    r.header_offset         = offs;
    r.hdr.header_word       = w;
    case (w[20:19])
      mafs_pkg::VID_MPEG1: r.hdr.mpeg_version = mafs_pkg::VER_MPEG1;
      mafs_pkg::VID_MPEG2: r.hdr.mpeg_version = mafs_pkg::VER_MPEG2;
      default:             r.hdr.mpeg_version = mafs_pkg::VER_MPEG25;
    endcase
    r.hdr.layer_number      = 2'(3'd4 - {1'b0, w[18:17]});
    r.hdr.bitrate_index     = w[15:12];
    r.hdr.free_format       = (w[15:12] == 4'd0);
    r.hdr.sample_rate_index = w[11:10];
    r.hdr.channel_mode      = w[7:6];
    return r;
  endfunction

  // advances the scan model by one accepted byte, returns 1 when a result is due
  function automatic bit scan_byte(input logic [7:0] b, input logic sof, input logic eof,
                                   output mafs_pkg::result_t r);
    logic [31:0] cur;
    logic [27:0] tag_len;
    logic [15:0] aid_len;
    int          first;
    int          s;
    bit          hit;
    bit          settled;
    hit = 1'b0;
    settled = 1'b0;
    r = '0;
    if (sof) begin
      for (s = 0; s < 10; s++) window[s] = 8'd0;
      file_pos    = '0;
      skip_left   = '0;
      window_fill = 0;
      phase       = SCAN_PROLOGUE;
    end
    if (phase == SCAN_WAIT || phase == SCAN_FINISHED) return 1'b0;
    cur = file_pos;
    file_pos = file_pos + 32'd1;
    for (s = 0; s < 9; s++) window[s] = window[s+1];
    window[9] = b;
    case (phase)
      SCAN_PROLOGUE: begin
        window_fill++;
        if (window_fill >= 10) begin
          if ({window[0], window[1], window[2]} == mafs_pkg::ID3_MAGIC) begin
            tag_len = {window[6][6:0], window[7][6:0], window[8][6:0], window[9][6:0]};
            window_fill = 0;
            if (tag_len == '0) begin
              phase = SCAN_PROLOGUE;
            end else begin
              skip_left = tag_len;
              phase = SCAN_TAG_SKIP;
            end
          end else begin
            first = 0;
            if ({window[0], window[1], window[2], window[3]} == mafs_pkg::AID_MAGIC) begin
              aid_len = {window[5], window[4]};
              if (aid_len >= 16'd4) begin
                window_fill = 0;
                skip_left = 28'(aid_len - 16'd4);
                phase = (skip_left == '0) ? SCAN_SEARCH : SCAN_AID_SKIP;
                settled = 1'b1;
              end else begin
                first = 6 + int'(aid_len);
              end
            end
            if (!settled) begin
              // windows lying wholly inside the ten collected bytes
              for (s = first; s <= 6 && !hit; s++) begin
                if (frame_header_ok({window[s], window[s+1], window[s+2], window[s+3]})) begin
                  r = header_result({window[s], window[s+1], window[s+2], window[s+3]},
                                    cur - 32'd9 + 32'(s));
                  phase = SCAN_FINISHED;
                  hit = 1'b1;
                end
              end
              if (!hit) begin
                window_fill = (10 - first < 3) ? 10 - first : 3;
                phase = SCAN_SEARCH;
              end
            end
          end
        end
      end
      SCAN_TAG_SKIP, SCAN_AID_SKIP: begin
        if (skip_left != '0) skip_left = skip_left - 28'd1;
        if (skip_left == '0) begin
          window_fill = 0;
          phase = (phase == SCAN_TAG_SKIP) ? SCAN_PROLOGUE : SCAN_SEARCH;
        end
      end
      default: begin
        if (window_fill < 4) window_fill++;
        if (window_fill >= 4 && frame_header_ok({window[6], window[7], window[8], window[9]}))
        begin
          r = header_result({window[6], window[7], window[8], window[9]}, cur - 32'd3);
          phase = SCAN_FINISHED;
          hit = 1'b1;
        end
      end
    endcase
    if (eof && !hit) begin
      r = '0;
      phase = SCAN_FINISHED;
      hit = 1'b1;
    end
    return hit;
  endfunction

  // random frame header, sane or with exactly one fault
  function automatic logic [31:0] make_header(input bit sane);
    logic [1:0]    vid;
    logic [1:0]    lid;
    logic [1:0]    sri;
    logic [1:0]    mode;
    logic [1:0]    emph;
    logic [3:0]    bri;
    logic [31:0]   w;
    header_fault_t fault;
    do vid = 2'($urandom_range(3)); while (vid == mafs_pkg::VID_RESVD);
    do lid = 2'($urandom_range(3)); while (lid == mafs_pkg::LID_RESVD);
    do bri = 4'($urandom_range(15)); while (bri == mafs_pkg::BRI_BAD);
    do sri = 2'($urandom_range(3)); while (sri == mafs_pkg::SRI_BAD);
    do emph = 2'($urandom_range(3)); while (emph == mafs_pkg::EMPH_BAD);
    mode = 2'($urandom_range(3));
    fault = header_fault_t'($urandom_range(FLT_L2_MODE));
    if (!sane) begin
      case (fault)
        FLT_VERSION:  vid = mafs_pkg::VID_RESVD;
        FLT_LAYER:    lid = mafs_pkg::LID_RESVD;
        FLT_BITRATE:  bri = mafs_pkg::BRI_BAD;
        FLT_RATE:     sri = mafs_pkg::SRI_BAD;
        FLT_EMPHASIS: emph = mafs_pkg::EMPH_BAD;
        FLT_L2_MODE: begin
          vid = mafs_pkg::VID_MPEG1;
          lid = mafs_pkg::LID_LAYER2;
          bri = (mode == mafs_pkg::MODE_MONO) ? 4'($urandom_range(14, 11)) :
                                                4'($urandom_range(3, 1));
        end
        default: ;
      endcase
    end
    w = {mafs_pkg::SYNC_BYTE, mafs_pkg::SYNC_HIGH, vid, lid, 1'($urandom_range(1)), bri, sri,
         2'($urandom_range(3)), mode, 4'($urandom_range(15)), emph};
    if (!sane && fault == FLT_SYNC) w[21 + $urandom_range(10)] = 1'b0;
    return w;
  endfunction

  task automatic push_header(input logic [31:0] w);
    file_bytes.push_back(w[31:24]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endtask

  task automatic emit_file(input bit with_eof, input bit wait_drain);
    file_byte_t it;
    foreach (file_bytes[i]) begin
      it.data  = file_bytes[i];
      it.sof   = (i == 0);
      it.eof   = with_eof && (i == file_bytes.size() - 1);
      it.drain = wait_drain && (i == 0);
      pending_bytes.push_back(it);
    end
    file_bytes.delete();
  endtask

  // bytes without a start flag; outside a file the block drops them
  task automatic add_noise(input int count);
    file_byte_t it;
    repeat (count) begin
      it.data  = 8'($urandom);
      it.sof   = 1'b0;
      it.eof   = 1'($urandom_range(1));
      it.drain = 1'b0;
      pending_bytes.push_back(it);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  initial begin
    int          files;
    int          file_items;
    int          tags;
    bit          cut;
    logic [27:0] tag_len;
    logic [15:0] aid_len;
    files = 0;
    file_items = 0;

    // directed: bytes before any start, restart mid-file, header in final window,
    // bytes after a result, short prologue, zero-length aid with free format
    add_noise(2);
    file_bytes = '{mafs_pkg::SYNC_BYTE, 8'hFB, 8'h90};
    emit_file(1'b0, 1'b0);
    file_bytes = '{mafs_pkg::SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    push_header(32'hFFE7EBFF);
    emit_file(1'b1, 1'b0);
    add_noise(2);
    file_bytes = '{mafs_pkg::SYNC_BYTE, 8'hFB, 8'h90, 8'h64};
    emit_file(1'b1, 1'b0);
    file_bytes = '{mafs_pkg::AID_MAGIC[31:24], mafs_pkg::AID_MAGIC[23:16],
                   mafs_pkg::AID_MAGIC[15:8], mafs_pkg::AID_MAGIC[7:0], 8'h00, 8'h00};
    push_header(32'hFFE20000);
    emit_file(1'b1, 1'b0);

    // random files
    while (file_items < FILE_BYTES) begin
      cut = 1'b0;
      tags = ($urandom_range(99) < 30) ? $urandom_range(2, 1) : 0;
      repeat (tags) begin
        if (!cut) begin
          case ($urandom_range(9))
            0:       tag_len = '0;
            1:       tag_len = 28'($urandom);
            default: tag_len = 28'($urandom_range(12, 1));
          endcase
          file_bytes.push_back(mafs_pkg::ID3_MAGIC[23:16]);
          file_bytes.push_back(mafs_pkg::ID3_MAGIC[15:8]);
          file_bytes.push_back(mafs_pkg::ID3_MAGIC[7:0]);
          repeat (3) file_bytes.push_back(8'($urandom));
          // top bit of each size byte is not part of the length
          file_bytes.push_back({1'($urandom), tag_len[27:21]});
          file_bytes.push_back({1'($urandom), tag_len[20:14]});
          file_bytes.push_back({1'($urandom), tag_len[13:7]});
          file_bytes.push_back({1'($urandom), tag_len[6:0]});
          if (tag_len > 28'd64) begin
            repeat ($urandom_range(8)) file_bytes.push_back(8'($urandom));
            cut = 1'b1;
          end else begin
            repeat (tag_len) file_bytes.push_back(8'($urandom));
          end
        end
      end
      if (!cut && $urandom_range(99) < 25) begin
        case ($urandom_range(9))
          0, 1:    aid_len = 16'($urandom_range(3));
          2:       aid_len = 16'($urandom);
          default: aid_len = 16'($urandom_range(16, 4));
        endcase
        file_bytes.push_back(mafs_pkg::AID_MAGIC[31:24]);
        file_bytes.push_back(mafs_pkg::AID_MAGIC[23:16]);
        file_bytes.push_back(mafs_pkg::AID_MAGIC[15:8]);
        file_bytes.push_back(mafs_pkg::AID_MAGIC[7:0]);
        file_bytes.push_back(aid_len[7:0]);
        file_bytes.push_back(aid_len[15:8]);
        if (aid_len > 16'd64) begin
          repeat ($urandom_range(8)) file_bytes.push_back(8'($urandom));
          cut = 1'b1;
        end else begin
          repeat (aid_len) file_bytes.push_back(8'($urandom));
        end
      end
      if (!cut) begin
        repeat ($urandom_range(8))
          file_bytes.push_back(($urandom_range(4) == 0) ? mafs_pkg::SYNC_BYTE : 8'($urandom));
        if ($urandom_range(99) < 30) push_header(make_header(1'b0));
        if ($urandom_range(99) < 75) push_header(make_header(1'b1));
        repeat ($urandom_range(4)) file_bytes.push_back(8'($urandom));
      end
      if (file_bytes.size() > 1 && $urandom_range(99) < 8) begin
        repeat ($urandom_range(file_bytes.size() - 1, 1))
          file_bytes.delete(file_bytes.size() - 1);
      end
      if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom));
      file_items += file_bytes.size();
      emit_file($urandom_range(99) >= 6, files == 0 || files == 20);
      files++;
      if ($urandom_range(99) < 12) add_noise($urandom_range(3, 1));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("streamed %0d bytes in %0d random files plus directed cases", bytes_sent, files);
    $display("headers reported: %0d, files ended without one: %0d",
             headers_found, files_missed);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // byte source
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || byte_taken) begin
        offer = 1'b0;
        if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          if (!pending_bytes[0].drain || expected_results.size() == 0) offer = 1'b1;
        end
        if (offer) begin
          next_byte = pending_bytes.pop_front();
          s_axis_tdata  <= next_byte.data;
          s_axis_tuser  <= next_byte.sof;
          s_axis_tlast  <= next_byte.eof;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink, with one long hold-off so the input side backs up
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && bytes_sent >= 650) begin
        hold_left <= 120;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_sent <= bytes_sent + 1;
        if (scan_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, fresh))
          expected_results.push_back(fresh);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation: found %b tdata %h",
                 m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("found", want.found, m_axis_tuser);
          check_field("header_offset", want.header_offset, m_axis_tdata[31:0]);
          check_field("header_word", want.hdr.header_word, m_axis_tdata[63:32]);
          check_field("mpeg_version", want.hdr.mpeg_version, m_axis_tdata[65:64]);
          check_field("layer_number", want.hdr.layer_number, m_axis_tdata[67:66]);
          check_field("bitrate_index", want.hdr.bitrate_index, m_axis_tdata[71:68]);
          check_field("free_format", want.hdr.free_format, m_axis_tdata[72]);
          check_field("sample_rate_index", want.hdr.sample_rate_index, m_axis_tdata[74:73]);
          check_field("channel_mode", want.hdr.channel_mode, m_axis_tdata[76:75]);
          check_field("tdata fill", '0, 32'(m_axis_tdata >> RESULT_DATA_W));
          if (want.found) headers_found++;
          else files_missed++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== mpeg_audio_frame_sync_scanner_unit.f =====
sv/mafs_pkg.sv
sv/mafs_hdr_check.sv
sv/mafs_scan_core.sv
sv/mpeg_audio_frame_sync_scanner_unit.sv
sv/mafs_sva.sv
verif/mpeg_audio_frame_sync_scanner_unit_tb.sv
